@@ sv/ntc_pkg.sv @@
// Shared constants, types and log table for the NTC Beta temperature unit.
// No dependencies.
`default_nettype none

package ntc_pkg;

  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned XW = 37;  // resistance product width
  localparam int unsigned QB = 17;  // quotient bits of the divider row
  localparam int unsigned TabN = 17;

  localparam logic [63:0] Nano = 64'd1000000000;
  localparam logic signed [17:0] OutMax = 18'sd99999;
  localparam logic signed [17:0] OutErr = -18'sd99900;
  localparam logic [16:0] ZeroCCenti = 17'd27315;
  localparam logic [16:0] TkMax = 17'd127314;

  typedef enum logic [2:0] {
    RegSupply = 3'd0,
    RegFixedR = 3'd1,
    RegRefR   = 3'd2,
    RegRefT   = 3'd3,
    RegBeta   = 3'd4
  } ntc_reg_e;

  typedef struct packed {
    logic fault;
    logic sat;
  } ntc_flags_t;

  // ln(1+k/16) in units of 1e-9
  localparam logic [31:0] LnTabNano [TabN] = '{
    32'd0, 32'd60624622, 32'd117783036, 32'd171850257, 32'd223143551,
    32'd271933715, 32'd318453731, 32'd362905494, 32'd405465108,
    32'd446287103, 32'd485507816, 32'd523248144, 32'd559615788,
    32'd594707108, 32'd628608659, 32'd661398482, 32'd693147181
  };

  function automatic logic [63:0] nano_fx(int unsigned idx, int unsigned fb);
    logic [63:0] n;
    n = 64'(LnTabNano[idx]);
    return ((n << fb) + (Nano >> 1)) / Nano;
  endfunction

endpackage

`default_nettype wire

@@ sv/ntc_beta_temperature_unit.sv @@
// NTC thermistor Beta-equation temperature unit: one millivolt sample in,
// temperature in 0.01 degC out. Uses ntc_pkg, ntc_ln and ntc_div_cell.
//
// Fully pipelined: one item per cycle while the pipe is not held. The
// depth is set by the row of 17 divider cells (one quotient bit each)
// behind ten front stages for clamp, resistance products, the two
// four-stage log units and the Beta denominator; each result is then
// written into a two-entry output buffer, which lets input continue
// while one result waits; the whole pipe holds only when both entries
// are full. Configuration writes are always ready and take effect at once.
`default_nettype none

module ntc_beta_temperature_unit import ntc_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [12:0] adc_mv_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [17:0] temp_centi_c_o,
  output logic        fault_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i
);

  localparam int unsigned LW = FRAC_BITS + 5;
  localparam int unsigned DW = FRAC_BITS + 23;
  localparam int unsigned NW = FRAC_BITS + 37;
  localparam int unsigned RW = FRAC_BITS + 38;
  localparam int unsigned CW = RW + 1;
  localparam int unsigned LnLat = 4;

  // configuration
  logic [12:0] supply_q;
  logic [19:0] rf_q, r0_q;
  logic [15:0] t0_q;
  logic [13:0] beta_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      supply_q <= 13'd3300;
      rf_q     <= 20'd10000;
      r0_q     <= 20'd10000;
      t0_q     <= 16'd29815;
      beta_q   <= 14'd3950;
    end else if (cfg_valid_i) begin
      case (ntc_reg_e'(cfg_index_i))
        RegSupply: supply_q <= cfg_data_i[12:0];
        RegFixedR: rf_q     <= cfg_data_i;
        RegRefR:   r0_q     <= cfg_data_i;
        RegRefT:   t0_q     <= cfg_data_i[15:0];
        RegBeta:   beta_q   <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  // output buffer state
  logic [1:0]  cnt_q;
  logic        wp_q, rp_q;
  logic [17:0] ent_t_q [2];
  logic        ent_f_q [2];
  logic        adv_w;

  assign adv_w      = cnt_q != 2'd2;
  assign in_ready_o = adv_w;

  // stage 1: clamp and fault check
  logic [16:0]        v10_w, s10_w, vc_w;
  logic signed [17:0] smax_w, vin_w, vcl_w;
  logic               f1_w;

  always_comb begin
    v10_w  = 17'(adc_mv_i) * 17'd10;
    s10_w  = 17'(supply_q) * 17'd10;
    smax_w = $signed({1'b0, s10_w}) - 18'sd1;
    vin_w  = $signed({1'b0, v10_w});
    vcl_w  = (vin_w > smax_w) ? smax_w : vin_w;
    if (vcl_w < 18'sd1) vcl_w = 18'sd1;
    vc_w   = vcl_w[16:0];
    f1_w   = (rf_q == 20'd0) || (s10_w <= vc_w);
  end

  logic        s1_vld_q, s1_flt_q;
  logic [16:0] s1_vc_q, s1_sv_q;

  // stage 2: resistance products
  logic          s2_vld_q, s2_flt_q;
  logic [XW-1:0] s2_num_q, s2_den_q;
  logic [19:0]   r0e_w;

  assign r0e_w = (r0_q == 20'd0) ? 20'd1 : r0_q;

  // log units
  logic [LW-1:0] ln_num_w, ln_den_w;
  logic          lnv_q [LnLat];
  logic          lnf_q [LnLat];

  ntc_ln #(.FRAC_BITS(FRAC_BITS)) u_ln_num (
    .clk_i (clk_i),
    .adv_i (adv_w),
    .x_i   (s2_num_q),
    .ln_o  (ln_num_w)
  );

  ntc_ln #(.FRAC_BITS(FRAC_BITS)) u_ln_den (
    .clk_i (clk_i),
    .adv_i (adv_w),
    .x_i   (s2_den_q),
    .ln_o  (ln_den_w)
  );

  // stage 7: log ratio
  logic               s7_vld_q, s7_flt_q;
  logic signed [LW:0] s7_l_q;

  // stage 8: products with T0
  logic                 s8_vld_q, s8_flt_q;
  logic signed [DW-1:0] s8_p_q;
  logic [29:0]          s8_tb_q;
  logic signed [DW-1:0] t0s_w, ls_w;

  assign t0s_w = $signed(DW'(t0_q));
  assign ls_w  = $signed({{(DW-LW-1){s7_l_q[LW]}}, s7_l_q});

  // stage 9: denominator and numerator
  logic                 s9_vld_q;
  ntc_flags_t           s9_flg_q;
  logic [DW-1:0]        s9_dn_q;
  logic [NW-1:0]        s9_nm_q;
  logic signed [DW-1:0] dn_w;
  logic [NW-1:0]        nm_w;

  assign dn_w = $signed((DW'(beta_q) * DW'(100)) << FRAC_BITS) + s8_p_q;
  assign nm_w = (NW'(s8_tb_q) * NW'(100)) << FRAC_BITS;

  // stage 10: rounded dividend and range check
  logic [RW-1:0] dvd_w;
  logic [CW-1:0] lim_w;

  assign dvd_w = RW'(s9_nm_q) + RW'(s9_dn_q >> 1);
  assign lim_w = CW'(s9_dn_q) << QB;

  // divider row
  logic          c_vld [QB+1];
  logic [RW-1:0] c_rem [QB+1];
  logic [DW-1:0] c_dn  [QB+1];
  logic [QB-1:0] c_q   [QB+1];
  ntc_flags_t    c_flg [QB+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      for (int k = 0; k < LnLat; k++) lnv_q[k] <= 1'b0;
      s7_vld_q <= 1'b0;
      s8_vld_q <= 1'b0;
      s9_vld_q <= 1'b0;
      c_vld[0] <= 1'b0;
    end else if (adv_w) begin
      s1_vld_q <= in_valid_i;
      s2_vld_q <= s1_vld_q;
      lnv_q[0] <= s2_vld_q;
      for (int k = 1; k < LnLat; k++) lnv_q[k] <= lnv_q[k-1];
      s7_vld_q <= lnv_q[LnLat-1];
      s8_vld_q <= s7_vld_q;
      s9_vld_q <= s8_vld_q;
      c_vld[0] <= s9_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_w) begin
      s1_vc_q  <= vc_w;
      s1_sv_q  <= s10_w - vc_w;
      s1_flt_q <= f1_w;
      s2_num_q <= XW'(rf_q) * XW'(s1_sv_q);
      s2_den_q <= XW'(s1_vc_q) * XW'(r0e_w);
      s2_flt_q <= s1_flt_q;
      lnf_q[0] <= s2_flt_q;
      for (int k = 1; k < LnLat; k++) lnf_q[k] <= lnf_q[k-1];
      s7_l_q   <= $signed({1'b0, ln_num_w}) - $signed({1'b0, ln_den_w});
      s7_flt_q <= lnf_q[LnLat-1];
      s8_p_q   <= t0s_w * ls_w;
      s8_tb_q  <= 30'(t0_q) * 30'(beta_q);
      s8_flt_q <= s7_flt_q;
      s9_dn_q  <= dn_w;
      s9_nm_q  <= nm_w;
      s9_flg_q.fault <= s8_flt_q;
      s9_flg_q.sat   <= dn_w[DW-1] || (dn_w == '0);
      c_rem[0] <= dvd_w;
      c_dn[0]  <= s9_dn_q;
      c_q[0]   <= '0;
      c_flg[0].fault <= s9_flg_q.fault;
      c_flg[0].sat   <= s9_flg_q.sat || (CW'(dvd_w) >= lim_w);
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    ntc_div_cell #(.RW(RW), .DW(DW), .J(QB - 1 - j)) u_div_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv_w),
      .valid_i (c_vld[j]),
      .rem_i   (c_rem[j]),
      .dn_i    (c_dn[j]),
      .q_i     (c_q[j]),
      .flg_i   (c_flg[j]),
      .valid_o (c_vld[j+1]),
      .rem_o   (c_rem[j+1]),
      .dn_o    (c_dn[j+1]),
      .q_o     (c_q[j+1]),
      .flg_o   (c_flg[j+1])
    );
  end

  // result formatting
  logic [17:0] res_t_w;
  logic        res_f_w;

  always_comb begin
    res_f_w = 1'b0;
    if (c_flg[QB].fault) begin
      res_t_w = OutErr;
      res_f_w = 1'b1;
    end else if (c_flg[QB].sat || (c_q[QB] > TkMax)) begin
      res_t_w = OutMax;
    end else begin
      res_t_w = 18'(c_q[QB]) - 18'(ZeroCCenti);
    end
  end

  // output buffer
  logic push_w, pop_w;

  assign push_w = adv_w && c_vld[QB];
  assign pop_w  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      if (push_w) wp_q <= ~wp_q;
      if (pop_w)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_w) - 2'(pop_w);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_w) begin
      ent_t_q[wp_q] <= res_t_w;
      ent_f_q[wp_q] <= res_f_w;
    end
  end

  assign out_valid_o    = cnt_q != 2'd0;
  assign temp_centi_c_o = ent_t_q[rp_q];
  assign fault_o        = ent_f_q[rp_q];

  ap_fault_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fault_o |-> temp_centi_c_o == OutErr)
    else $error("fault item without error code");

  ap_kelvin_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !fault_o |-> $signed(temp_centi_c_o) >= -18'sd27315)
    else $error("temperature below absolute zero");

  ap_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_w && c_vld[QB] |=> c_vld[QB] && $stable(c_q[QB]))
    else $error("divider output moved during stall");

  ap_buf_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output buffer overflow");

endmodule

`default_nettype wire

@@ sv/ntc_ln.sv @@
// Four-stage fixed-point natural log: leading-one search, normalize,
// table lookup with interpolation product, final add. Uses ntc_pkg.
`default_nettype none

module ntc_ln import ntc_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 adv_i,
  input  logic [XW-1:0]        x_i,
  output logic [FRAC_BITS+4:0] ln_o
);

  localparam int unsigned LW = FRAC_BITS + 5;
  localparam int unsigned TW = FRAC_BITS;
  localparam int unsigned PW = 2 * FRAC_BITS;

  logic [TW-1:0] tab_w [TabN];

  for (genvar g = 0; g < TabN; g++) begin : g_tab
    localparam logic [63:0] TabVal = nano_fx(g, FRAC_BITS);
    assign tab_w[g] = TabVal[TW-1:0];
  end

  // stage a: leading one
  logic [5:0]    e_w;
  logic [XW-1:0] x_q;
  logic [5:0]    e_q;

  always_comb begin
    e_w = 6'd0;
    for (int i = 0; i < XW; i++) begin
      if (x_i[i]) e_w = 6'(i);
    end
  end

  // stage b: normalize
  logic [XW-1:0]        xn_w;
  logic [5:0]           e2_q;
  logic [3:0]           idx_q;
  logic [FRAC_BITS-1:0] rem_q;

  assign xn_w = x_q << (6'(XW - 1) - e_q);

  // stage c: lookup and interpolation product
  logic [TW-1:0] a_w, b_w;
  logic [LW-1:0] base_q;
  logic [PW-1:0] prod_q;

  assign a_w = tab_w[{1'b0, idx_q}];
  assign b_w = tab_w[{1'b0, idx_q} + 5'd1];

  // stage d: sum
  logic [LW-1:0] ln_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x_q    <= x_i;
      e_q    <= e_w;
      e2_q   <= e_q;
      idx_q  <= xn_w[XW-2 -: 4];
      rem_q  <= xn_w[XW-6 -: FRAC_BITS];
      base_q <= LW'(e2_q) * LW'(tab_w[TabN-1]) + LW'(a_w);
      prod_q <= PW'(b_w - a_w) * PW'(rem_q);
      ln_q   <= base_q + LW'(prod_q >> FRAC_BITS);
    end
  end

  assign ln_o = ln_q;

endmodule

`default_nettype wire

@@ sv/ntc_div_cell.sv @@
// One restoring-division cell: resolves one quotient bit and hands the
// partial remainder to the next cell. Uses ntc_pkg.
`default_nettype none

module ntc_div_cell import ntc_pkg::*; #(
  parameter int unsigned RW = 54,
  parameter int unsigned DW = 39,
  parameter int unsigned J  = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          valid_i,
  input  logic [RW-1:0] rem_i,
  input  logic [DW-1:0] dn_i,
  input  logic [QB-1:0] q_i,
  input  ntc_flags_t    flg_i,
  output logic          valid_o,
  output logic [RW-1:0] rem_o,
  output logic [DW-1:0] dn_o,
  output logic [QB-1:0] q_o,
  output ntc_flags_t    flg_o
);

  localparam int unsigned CW = RW + 1;

  logic [CW-1:0] trial_w;
  logic          ge_w;

  assign trial_w = CW'(dn_i) << J;
  assign ge_w    = CW'(rem_i) >= trial_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (adv_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rem_o <= ge_w ? rem_i - trial_w[RW-1:0] : rem_i;
      dn_o  <= dn_i;
      q_o   <= {q_i[QB-2:0], ge_w};
      flg_o <= flg_i;
    end
  end

endmodule

`default_nettype wire
